// ----- rtl/core/ordered_list_store_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Ordered list store assertion macros
// Concurrent check macros that the top level uses; empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_STORE_UNIT_ASSERT_SVH
`define ORDERED_LIST_STORE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define OLS_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ordered list store check failed");

`define OLS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list store check failed");

`define OLS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list store check failed");

`else

`define OLS_ASSERT_ALWAYS(lbl, clk, rst, cond)

`define OLS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define OLS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/ols_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list store package
// Sizes, request and status codes, shared types and index arithmetic.
// ----------------------------------------------------------------------------
package ols_pkg;

   localparam int CAPACITY      = 16;
   localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int VALUE_W       = 32;
   localparam int COUNT_FIELD_W = 5;
   localparam int TYPE_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int REQ_TDATA_W   = ((VALUE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W   = ((VALUE_W + COUNT_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_TDATA_W - VALUE_W - COUNT_FIELD_W;

   localparam logic [CNT_W-1:0] CAPACITY_CNT = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(CAPACITY - 1);

   localparam logic [TYPE_W-1:0] REQ_FRONT  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_BACK   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_DUMP   = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] count;
   } ctrl_status_type;

   // physical slot of a list position in the circular entry memory
   function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] pos);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= (IDX_W + 1)'(CAPACITY)) begin
         sum = sum - (IDX_W + 1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ----- rtl/core/ols_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list store entry memory
// One write port and one registered read port; read data holds between reads.
// ----------------------------------------------------------------------------
module ols_mem (
   input  logic                             clock,
   input  ols_pkg::mem_req_type             mem_req,
   output logic [ols_pkg::VALUE_W-1:0]      rd_data
);

   logic [ols_pkg::VALUE_W-1:0] entries_ff [ols_pkg::CAPACITY];
   logic [ols_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entries_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= entries_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ols_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list store sequencer
// Runs insert, search, compaction and dump over the entry memory and holds
// the result word register.
// ----------------------------------------------------------------------------
module ols_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ols_pkg::TYPE_W-1:0]           req_type,
   input  logic [ols_pkg::VALUE_W-1:0]          req_value,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ols_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ols_pkg::VALUE_W-1:0]          rsp_element_value,
   output logic                                 rsp_last,
   output logic [ols_pkg::COUNT_FIELD_W-1:0]    rsp_entry_count,
   output ols_pkg::mem_req_type                 mem_req,
   input  logic [ols_pkg::VALUE_W-1:0]          mem_rd_data,
   output ols_pkg::ctrl_status_type             ctrl_status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_SHIFT  = 2'd2;
   localparam logic [1:0] ST_DUMP   = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic [ols_pkg::CNT_W-1:0]           count_ff, count_in;
   logic [ols_pkg::IDX_W-1:0]           head_ff, head_in;
   logic [ols_pkg::CNT_W-1:0]           rd_idx_ff, rd_idx_in;
   logic [ols_pkg::IDX_W-1:0]           chk_idx_ff, chk_idx_in;
   logic [ols_pkg::IDX_W-1:0]           wr_idx_ff, wr_idx_in;
   logic                                pend_ff, pend_in;
   logic [ols_pkg::VALUE_W-1:0]         value_ff, value_in;
   logic                                out_valid_ff, out_valid_in;
   logic [ols_pkg::STATUS_W-1:0]        out_status_ff, out_status_in;
   logic [ols_pkg::VALUE_W-1:0]         out_elem_ff, out_elem_in;
   logic                                out_last_ff, out_last_in;
   logic [ols_pkg::COUNT_FIELD_W-1:0]   out_count_ff, out_count_in;

   logic                                out_free;
   logic                                rd_issue;
   logic [ols_pkg::IDX_W-1:0]           rd_pos;
   logic                                chk_last;
   logic [ols_pkg::IDX_W-1:0]           front_head;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rd_issue   = rd_idx_ff < count_ff;
   assign rd_pos     = rd_idx_ff[ols_pkg::IDX_W-1:0];
   assign chk_last   = (ols_pkg::CNT_W'(chk_idx_ff) + ols_pkg::CNT_W'(1)) == count_ff;
   assign front_head = (head_ff == '0) ? ols_pkg::LAST_IDX
                                       : head_ff - ols_pkg::IDX_W'(1);
   assign req_tready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      wr_idx_in     = wr_idx_ff;
      pend_in       = pend_ff;
      value_in      = value_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_elem_in   = out_elem_ff;
      out_last_in   = out_last_ff;
      out_count_in  = out_count_ff;
      mem_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               out_elem_in = '0;
               out_last_in = 1'b1;
               unique case (req_type) inside
                  ols_pkg::REQ_FRONT, ols_pkg::REQ_BACK: begin
                     out_valid_in = 1'b1;
                     if (count_ff >= ols_pkg::CAPACITY_CNT) begin
                        out_status_in = ols_pkg::STAT_FULL;
                        out_count_in  = ols_pkg::COUNT_FIELD_W'(count_ff);
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_data = req_value;
                        if (req_type == ols_pkg::REQ_FRONT) begin
                           mem_req.wr_addr = front_head;
                           head_in         = front_head;
                        end else begin
                           mem_req.wr_addr = ols_pkg::wrap_idx(head_ff,
                              count_ff[ols_pkg::IDX_W-1:0]);
                        end
                        count_in      = count_ff + ols_pkg::CNT_W'(1);
                        out_status_in = ols_pkg::STAT_OK;
                        out_count_in  = ols_pkg::COUNT_FIELD_W'(count_in);
                     end
                  end
                  ols_pkg::REQ_DELETE, ols_pkg::REQ_DUMP: begin
                     if (count_ff == '0) begin
                        out_valid_in  = 1'b1;
                        out_status_in = ols_pkg::STAT_EMPTY;
                        out_count_in  = '0;
                     end else begin
                        value_in  = req_value;
                        rd_idx_in = '0;
                        pend_in   = 1'b0;
                        state_in  = (req_type == ols_pkg::REQ_DELETE) ? ST_SEARCH
                                                                      : ST_DUMP;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (out_free) begin
               // stream reads in list order, compare each word as its registered read data returns
               mem_req.rd_en   = rd_issue;
               mem_req.rd_addr = ols_pkg::wrap_idx(head_ff, rd_pos);
               pend_in         = rd_issue;
               if (rd_issue) begin
                  rd_idx_in  = rd_idx_ff + ols_pkg::CNT_W'(1);
                  chk_idx_in = rd_pos;
               end
               if (pend_ff) begin
                  if (mem_rd_data == value_ff) begin
                     wr_idx_in = chk_idx_ff;
                     state_in  = ST_SHIFT;
                  end else if (chk_last) begin
                     out_valid_in  = 1'b1;
                     out_status_in = ols_pkg::STAT_NOT_FOUND;
                     out_elem_in   = '0;
                     out_last_in   = 1'b1;
                     out_count_in  = ols_pkg::COUNT_FIELD_W'(count_ff);
                     state_in      = ST_IDLE;
                  end
               end
            end
         end
         ST_SHIFT: begin
            if (out_free) begin
               // move each later entry down by one to close the gap
               mem_req.rd_en   = rd_issue;
               mem_req.rd_addr = ols_pkg::wrap_idx(head_ff, rd_pos);
               pend_in         = rd_issue;
               if (rd_issue) begin
                  rd_idx_in  = rd_idx_ff + ols_pkg::CNT_W'(1);
                  chk_idx_in = rd_pos;
               end
               if (pend_ff) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = ols_pkg::wrap_idx(head_ff, wr_idx_ff);
                  mem_req.wr_data = mem_rd_data;
                  wr_idx_in       = wr_idx_ff + ols_pkg::IDX_W'(1);
               end else begin
                  count_in      = count_ff - ols_pkg::CNT_W'(1);
                  out_valid_in  = 1'b1;
                  out_status_in = ols_pkg::STAT_OK;
                  out_elem_in   = '0;
                  out_last_in   = 1'b1;
                  out_count_in  = ols_pkg::COUNT_FIELD_W'(count_in);
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               mem_req.rd_en   = rd_issue;
               mem_req.rd_addr = ols_pkg::wrap_idx(head_ff, rd_pos);
               pend_in         = rd_issue;
               if (rd_issue) begin
                  rd_idx_in  = rd_idx_ff + ols_pkg::CNT_W'(1);
                  chk_idx_in = rd_pos;
               end
               if (pend_ff) begin
                  out_valid_in  = 1'b1;
                  out_status_in = ols_pkg::STAT_OK;
                  out_elem_in   = mem_rd_data;
                  out_last_in   = chk_last;
                  out_count_in  = ols_pkg::COUNT_FIELD_W'(count_ff);
                  if (chk_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rd_idx_ff    <= '0;
         chk_idx_ff   <= '0;
         wr_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rd_idx_ff    <= rd_idx_in;
         chk_idx_ff   <= chk_idx_in;
         wr_idx_ff    <= wr_idx_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      out_status_ff <= out_status_in;
      out_elem_ff   <= out_elem_in;
      out_last_ff   <= out_last_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_tvalid        = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_element_value = out_elem_ff;
   assign rsp_last          = out_last_ff;
   assign rsp_entry_count   = out_count_ff;

   assign ctrl_status.busy  = (state_ff != ST_IDLE);
   assign ctrl_status.count = count_ff;

endmodule

// ----- rtl/core/ordered_list_store_unit.sv -----
`timescale 1ns / 1ps
// Insert response words are registered at accept. A delete searches to the
// match, then moves each entry behind it down by one; a dump gives one word per
// cycle while the response side accepts. Throughput: inserts 1 per cycle while
// the response side accepts; delete and dump use the single read port of the
// entry memory and hold off new requests until done. Reset: count and head
// clear at once; entry memory keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// Ordered list store unit
// Bounded ordered list of signed words held in a circular entry memory.
// ----------------------------------------------------------------------------
`include "ordered_list_store_unit_assert.svh"

module ordered_list_store_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] value
   input  logic [ols_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] req_type
   input  logic [ols_pkg::TYPE_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] element_value, [36:32] entry_count, rest zero
   output logic [ols_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [1:0] status
   output logic [ols_pkg::STATUS_W-1:0]        rsp_tuser,
   output logic                                rsp_tlast
);

   ols_pkg::mem_req_type                 mem_req;
   ols_pkg::ctrl_status_type             ctrl_status;
   logic [ols_pkg::VALUE_W-1:0]          mem_rd_data;
   logic [ols_pkg::VALUE_W-1:0]          rsp_element_value;
   logic [ols_pkg::COUNT_FIELD_W-1:0]    rsp_entry_count;

   ols_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   ols_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_type          (req_tuser),
      .req_value         (req_tdata[ols_pkg::VALUE_W-1:0]),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_status        (rsp_tuser),
      .rsp_element_value (rsp_element_value),
      .rsp_last          (rsp_tlast),
      .rsp_entry_count   (rsp_entry_count),
      .mem_req           (mem_req),
      .mem_rd_data       (mem_rd_data),
      .ctrl_status       (ctrl_status)
   );

   assign rsp_tdata = {{ols_pkg::RSP_PAD_W{1'b0}}, rsp_entry_count, rsp_element_value};

   `OLS_ASSERT_ALWAYS(a_count_bound, clock, reset, ctrl_status.count <= ols_pkg::CAPACITY_CNT)
   `OLS_ASSERT_IMPLIES(a_no_rw_same_slot, clock, reset, mem_req.wr_en && mem_req.rd_en, mem_req.wr_addr != mem_req.rd_addr)
   `OLS_ASSERT_IMPLIES(a_accept_slot_free, clock, reset, req_tvalid && req_tready, !rsp_tvalid || rsp_tready)
   `OLS_ASSERT_NEXT(a_busy_after_walk, clock, reset, req_tvalid && req_tready && (req_tuser == ols_pkg::REQ_DUMP) && (ctrl_status.count != '0), ctrl_status.busy)

endmodule

// ----- tb/ordered_list_store_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list store unit testbench
// A directed table opens the run: it covers both inserts at the field
// extremes, duplicate deletes, an empty list, a full list and dumps. Random
// request streams follow that grow the list to capacity and shrink it to
// empty. Every response word is checked, against the table's expected word or
// a shadow copy of the list. Both handshakes idle at random, and one long
// response stall backs up the request side.
// ----------------------------------------------------------------------------
module ordered_list_store_unit_test;

   localparam int N_ROWS     = 21;
   localparam int N_RANDOM   = 300;
   localparam int LIMIT      = 1000000;
   localparam int HOLD_LEN   = 300;
   localparam int DRAIN_WAIT = 40;

   typedef struct packed {
      logic [ols_pkg::STATUS_W-1:0]      status;
      logic [ols_pkg::VALUE_W-1:0]       elem;
      logic                              last;
      logic [ols_pkg::COUNT_FIELD_W-1:0] cnt;
   } rsp_word_type;

   typedef struct {
      logic [ols_pkg::TYPE_W-1:0]        kind;
      logic [ols_pkg::VALUE_W-1:0]       value;
      int                                reps;
      bit                                typed;
      logic [ols_pkg::STATUS_W-1:0]      status;
      logic [ols_pkg::COUNT_FIELD_W-1:0] cnt;
   } req_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ols_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [ols_pkg::TYPE_W-1:0]      req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ols_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [ols_pkg::STATUS_W-1:0]    rsp_tuser;
   logic                            rsp_tlast;

   logic [ols_pkg::VALUE_W-1:0] shadow_list[$];
   rsp_word_type                pending_rsp_q[$];
   int                          mismatches = 0;
   int                          accepted_reqs = 0;
   int                          cycle_cnt = 0;
   int                          rsp_stall = 0;
   bit                          hold_rsp = 1'b0;
   bit                          req_calm = 1'b0;
   bit                          rsp_calm = 1'b0;
   bit                          grow = 1'b1;

   logic [ols_pkg::VALUE_W-1:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                   32'h7FFF_FFFF, 32'h8000_0000,
                                                   32'h0000_0001, 32'h0000_0007,
                                                   32'hFFFF_FFF9, 32'h0000_0100};

   req_row_type dir_rows [N_ROWS] = '{
      '{ols_pkg::REQ_DUMP,   32'h0000_0000, 1, 1'b1, ols_pkg::STAT_EMPTY,     5'd0},
      '{ols_pkg::REQ_DELETE, 32'h0000_0005, 1, 1'b1, ols_pkg::STAT_EMPTY,     5'd0},
      '{ols_pkg::REQ_FRONT,  32'h7FFF_FFFF, 1, 1'b1, ols_pkg::STAT_OK,        5'd1},
      '{ols_pkg::REQ_BACK,   32'h8000_0000, 1, 1'b1, ols_pkg::STAT_OK,        5'd2},
      '{ols_pkg::REQ_FRONT,  32'hFFFF_FFFF, 1, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_BACK,   32'h0000_0000, 1, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_DUMP,   32'hFFFF_FFFF, 1, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_DELETE, 32'h0001_2345, 1, 1'b1, ols_pkg::STAT_NOT_FOUND, 5'd4},
      '{ols_pkg::REQ_BACK,   32'h8000_0000, 1, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_DELETE, 32'h8000_0000, 1, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_DUMP,   32'h0000_0000, 1, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_DELETE, 32'hFFFF_FFFF, 1, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_DELETE, 32'h8000_0000, 1, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_BACK,   32'hAAAA_AAAA, 7, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_FRONT,  32'h5555_5555, 7, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_FRONT,  32'h1234_5678, 1, 1'b1, ols_pkg::STAT_FULL,      5'd16},
      '{ols_pkg::REQ_BACK,   32'h8765_4321, 1, 1'b1, ols_pkg::STAT_FULL,      5'd16},
      '{ols_pkg::REQ_DUMP,   32'h0000_0000, 1, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_DELETE, 32'h5555_5555, 1, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_DELETE, 32'hAAAA_AAAA, 1, 1'b0, ols_pkg::STAT_OK,        5'd0},
      '{ols_pkg::REQ_DUMP,   32'h0000_0000, 1, 1'b0, ols_pkg::STAT_OK,        5'd0}
   };

   ordered_list_store_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] value
      .req_tuser  (req_tuser),   // [1:0] req_type
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] element_value, [36:32] entry_count
      .rsp_tuser  (rsp_tuser),   // [1:0] status
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic int gap_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   function automatic logic [ols_pkg::COUNT_FIELD_W-1:0] list_count();
      return ols_pkg::COUNT_FIELD_W'(shadow_list.size());
   endfunction

   // update the shadow list and, when record is set, queue the response words of one request
   task automatic apply_list_request(input logic [ols_pkg::TYPE_W-1:0] kind,
                                     input logic [ols_pkg::VALUE_W-1:0] val,
                                     input bit record);
      rsp_word_type words[$];
      int           hit;
      hit = -1;
      case (kind) inside
         ols_pkg::REQ_FRONT, ols_pkg::REQ_BACK: begin
            if (shadow_list.size() >= ols_pkg::CAPACITY) begin
               words.push_back('{ols_pkg::STAT_FULL, '0, 1'b1, list_count()});
            end else begin
               if (kind == ols_pkg::REQ_FRONT) shadow_list.push_front(val);
               else shadow_list.push_back(val);
               words.push_back('{ols_pkg::STAT_OK, '0, 1'b1, list_count()});
            end
         end
         ols_pkg::REQ_DELETE: begin
            if (shadow_list.size() == 0) begin
               words.push_back('{ols_pkg::STAT_EMPTY, '0, 1'b1, list_count()});
            end else begin
               for (int i = 0; i < shadow_list.size(); i++) begin
                  if (hit < 0 && shadow_list[i] == val) hit = i;
               end
               if (hit < 0) begin
                  words.push_back('{ols_pkg::STAT_NOT_FOUND, '0, 1'b1, list_count()});
               end else begin
                  shadow_list.delete(hit);
                  words.push_back('{ols_pkg::STAT_OK, '0, 1'b1, list_count()});
               end
            end
         end
         default: begin
            if (shadow_list.size() == 0) begin
               words.push_back('{ols_pkg::STAT_EMPTY, '0, 1'b1, list_count()});
            end else begin
               for (int i = 0; i < shadow_list.size(); i++) begin
                  words.push_back('{ols_pkg::STAT_OK, shadow_list[i],
                                    (i == shadow_list.size() - 1), list_count()});
               end
            end
         end
      endcase
      if (record) begin
         foreach (words[i]) pending_rsp_q.push_back(words[i]);
      end
   endtask

   task automatic send_request(input logic [ols_pkg::TYPE_W-1:0] kind,
                               input logic [ols_pkg::VALUE_W-1:0] val,
                               input bit typed,
                               input logic [ols_pkg::STATUS_W-1:0] t_status,
                               input logic [ols_pkg::COUNT_FIELD_W-1:0] t_cnt);
      int gap;
      gap = 0;
      if (!req_calm && !hold_rsp && $urandom_range(0, 3) == 0) gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= val;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_list_request(kind, val, !typed);
      if (typed) pending_rsp_q.push_back('{t_status, '0, 1'b1, t_cnt});
      accepted_reqs++;
      if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
   endtask

   task automatic send_random_request();
      logic [ols_pkg::TYPE_W-1:0]  kind;
      logic [ols_pkg::VALUE_W-1:0] val;
      int                          r;
      if (shadow_list.size() == ols_pkg::CAPACITY) grow = 1'b0;
      else if (shadow_list.size() == 0) grow = 1'b1;
      else if ($urandom_range(0, 29) == 0) grow = !grow;
      r   = $urandom_range(0, 99);
      val = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 7)] : $urandom;
      if (r < 12) begin
         kind = ols_pkg::REQ_DUMP;
      end else if (r < (grow ? 72 : 37)) begin
         kind = $urandom_range(0, 1) ? ols_pkg::REQ_FRONT : ols_pkg::REQ_BACK;
         if ($urandom_range(0, 9) < 6) val = $urandom;
      end else begin
         kind = ols_pkg::REQ_DELETE;
         if (shadow_list.size() > 0 && $urandom_range(0, 9) < 7)
            val = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
      end
      send_request(kind, val, 1'b0, ols_pkg::STAT_OK, '0);
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: status %0d elem %h last %b count %0d",
                        rsp_tuser, rsp_tdata[31:0], rsp_tlast, rsp_tdata[36:32]);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[31:0] !== want.elem ||
                rsp_tlast !== want.last || rsp_tdata[36:32] !== want.cnt) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected st %0d elem %h last %b cnt %0d,",
                            " got st %0d elem %h last %b cnt %0d"},
                           want.status, want.elem, want.last, want.cnt,
                           rsp_tuser, rsp_tdata[31:0], rsp_tlast, rsp_tdata[36:32]);
            end
         end
      end
      if ($urandom_range(0, 149) == 0) rsp_calm = !rsp_calm;
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (!rsp_calm && $urandom_range(0, 3) == 0) begin
         rsp_stall = gap_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // hold off responses so the request side backs up
   initial begin
      wait (accepted_reqs >= N_ROWS + 60);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         repeat (dir_rows[i].reps)
            send_request(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed,
                         dir_rows[i].status, dir_rows[i].cnt);
      end
      repeat (N_RANDOM) send_random_request();
      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && pending_rsp_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ols_pkg.sv
rtl/core/ols_mem.sv
rtl/core/ols_ctrl.sv
rtl/core/ordered_list_store_unit.sv
tb/ordered_list_store_unit_test.sv
